// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed: label");

`endif

// ===== hw/rtl/ska_pkg.sv =====
// Types and constants shared by the successor-after-k-steps block.
package ska_pkg;
   localparam int NODE_W       = 10;
   localparam int STEP_W       = 30;
   localparam int STEP_BITS    = 30;
   localparam int STEP_IDX_W   = 5;
   localparam int COUNT_W      = 11;
   localparam int NODES_DEF    = 1024;
   localparam int LEVELS_DEF   = 30;
   localparam int COUNT_RESET  = 1024;
   localparam int REQ_DATA_W   = 56;
   localparam int RSP_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_QUERY,
      OP_ECHO
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [NODE_W-1:0]   node;
      logic [NODE_W-1:0]   succ;
      logic [STEP_W-1:0]   steps;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RB_A,
      ST_RB_B,
      ST_RB_C,
      ST_Q_STEP,
      ST_Q_WAIT,
      ST_DONE
   } back_state_type;

   localparam logic REQ_CMD_LOAD = 1'b0;
endpackage

// ===== hw/rtl/ska_queue.sv =====
// Two-entry queue between the front and the back of the block.
module ska_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ska_pkg::entry_type  push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ska_pkg::entry_type  pop_data
);
   localparam int PW = $clog2(ska_pkg::QUEUE_DEPTH);

   ska_pkg::entry_type          slot_ff [ska_pkg::QUEUE_DEPTH];
   logic [PW-1:0]               wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]                 cnt_ff, cnt_in;
   logic                        push, pop;

   assign push_ready = cnt_ff != (PW+1)'(ska_pkg::QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_in  = push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule

// ===== hw/rtl/ska_front.sv =====
// Front end: accepts request items, drops bad loads and classifies the rest.
module ska_front (
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ska_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                         req_tuser,
   input  logic [16:0]                  node_count,
   output logic                         push_valid,
   input  logic                         push_ready,
   output ska_pkg::entry_type           push_data
);
   logic [ska_pkg::NODE_W-1:0] node, succ;
   logic                       node_ok, succ_ok, keep;

   assign node = req_tdata[9:0];
   assign succ = req_tdata[19:10];
   assign node_ok = 17'(node) < node_count;
   assign succ_ok = 17'(succ) < node_count;

   // Classify the item and drop out-of-range loads
   always_comb begin
      push_data.node  = node;
      push_data.succ  = succ;
      push_data.steps = req_tdata[49:20];
      keep = 1'b1;
      if (req_tuser == ska_pkg::REQ_CMD_LOAD) begin
         push_data.op = ska_pkg::OP_LOAD;
         keep = node_ok && succ_ok;
      end else if (node_ok) begin
         push_data.op = ska_pkg::OP_QUERY;
      end else begin
         push_data.op = ska_pkg::OP_ECHO;
      end
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid && keep;
endmodule

// ===== hw/rtl/ska_back.sv =====
// Back end: jump table memory, rebuild sequencer and query walker.
module ska_back #(
   parameter int NODES  = ska_pkg::NODES_DEF,
   parameter int LEVELS = ska_pkg::LEVELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  ska_pkg::entry_type             pop_data,
   output logic                           idle,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ska_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   localparam int NW   = $clog2(NODES);
   localparam int LVB  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int LW   = $clog2(LEVELS + 1);
   localparam int AW   = LVB + NW;
   localparam int QLIM = (LEVELS < ska_pkg::STEP_BITS) ? LEVELS : ska_pkg::STEP_BITS;
   localparam int VW   = ska_pkg::NODE_W;

   ska_pkg::back_state_type st_ff, st_in;
   logic [LW-1:0]           lv_ff, lv_in;
   logic [NW-1:0]           n_ff, n_in;
   logic [VW-1:0]           cur_ff, cur_in;
   logic [ska_pkg::STEP_W-1:0] steps_ff, steps_in;
   logic                    stale_ff, stale_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]           rsp_data_ff, rsp_data_in;
   logic [VW-1:0]           rd_ff;
   logic [VW-1:0]           mem [2**AW];
   logic [AW-1:0]           rd_addr, wr_addr;
   logic [VW-1:0]           wr_data;
   logic                    wr_en;
   logic [NW-1:0]           rd_idx, cur_idx;
   logic                    step_bit;

   // Map a stored node value to a table column, out-of-range to node 0
   assign rd_idx  = (32'(rd_ff) >= NODES) ? '0 : NW'(rd_ff);
   assign cur_idx = (32'(cur_ff) >= NODES) ? '0 : NW'(cur_ff);
   assign step_bit = steps_ff[ska_pkg::STEP_IDX_W'(lv_ff)];

   assign idle       = st_ff == ska_pkg::ST_IDLE;
   assign pop_ready  = idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ska_pkg::RSP_DATA_W'(rsp_data_ff);

   // Sequence loads, rebuild passes and query steps
   always_comb begin
      st_in        = st_ff;
      lv_in        = lv_ff;
      n_in         = n_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      stale_in     = stale_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rd_addr      = '0;
      wr_addr      = {LVB'(0), NW'(pop_data.node)};
      wr_data      = pop_data.succ;
      wr_en        = 1'b0;
      case (st_ff)
         ska_pkg::ST_IDLE: begin
            if (pop_valid) begin
               cur_in   = pop_data.node;
               steps_in = pop_data.steps;
               lv_in    = '0;
               n_in     = '0;
               case (pop_data.op)
                  ska_pkg::OP_LOAD: begin
                     wr_en    = 1'b1;
                     stale_in = 1'b1;
                  end
                  ska_pkg::OP_QUERY: begin
                     if (stale_ff && LEVELS > 1) begin
                        lv_in = LW'(1);
                        st_in = ska_pkg::ST_RB_A;
                     end else begin
                        st_in = ska_pkg::ST_Q_STEP;
                     end
                  end
                  default: st_in = ska_pkg::ST_DONE;
               endcase
            end
         end
         ska_pkg::ST_RB_A: begin
            rd_addr = {LVB'(lv_ff - LW'(1)), n_ff};
            st_in   = ska_pkg::ST_RB_B;
         end
         ska_pkg::ST_RB_B: begin
            rd_addr = {LVB'(lv_ff - LW'(1)), rd_idx};
            st_in   = ska_pkg::ST_RB_C;
         end
         ska_pkg::ST_RB_C: begin
            wr_en   = 1'b1;
            wr_addr = {LVB'(lv_ff), n_ff};
            wr_data = rd_ff;
            st_in   = ska_pkg::ST_RB_A;
            if (n_ff == NW'(NODES - 1)) begin
               n_in = '0;
               if (lv_ff == LW'(LEVELS - 1)) begin
                  stale_in = 1'b0;
                  lv_in    = '0;
                  st_in    = ska_pkg::ST_Q_STEP;
               end else begin
                  lv_in = lv_ff + LW'(1);
               end
            end else begin
               n_in = n_ff + NW'(1);
            end
         end
         ska_pkg::ST_Q_STEP: begin
            if (lv_ff == LW'(QLIM)) begin
               st_in = ska_pkg::ST_DONE;
            end else if (step_bit) begin
               rd_addr = {LVB'(lv_ff), cur_idx};
               st_in   = ska_pkg::ST_Q_WAIT;
            end else begin
               lv_in = lv_ff + LW'(1);
            end
         end
         ska_pkg::ST_Q_WAIT: begin
            cur_in = rd_ff;
            lv_in  = lv_ff + LW'(1);
            st_in  = ska_pkg::ST_Q_STEP;
         end
         ska_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = cur_ff;
               st_in        = ska_pkg::ST_IDLE;
            end
         end
         default: st_in = ska_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ska_pkg::ST_IDLE;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lv_ff       <= lv_in;
      n_ff        <= n_in;
      cur_ff      <= cur_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Jump table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end
endmodule

// ===== hw/rtl/successor_after_k_steps_top.sv =====
// Top level of the successor-after-k-steps block.
// Load item: written to the table while the back end is idle, no result.
// Query: the back end steps through each level and reads the table once per set step bit,
// then sends the result; one query runs in the back end at a time.
// The first query after a load first runs the rebuild of the table's upper levels.
// Synchronous reset marks the table stale and sets node_count to 1024 (or NODES).
`include "assert_macros.svh"
module successor_after_k_steps_top #(
   parameter int NODES  = ska_pkg::NODES_DEF,
   parameter int LEVELS = ska_pkg::LEVELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // node[9:0], successor[19:10], steps[49:20], zero[55:50]
   input  logic [ska_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // end_node[9:0], zero[15:10]
   output logic [ska_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [ska_pkg::COUNT_W-1:0]    csr_wdata
);
   localparam int CNT_RST = (ska_pkg::COUNT_RESET < NODES) ? ska_pkg::COUNT_RESET : NODES;

   logic [16:0]        count_ff, count_in;
   logic               push_valid, push_ready, pop_valid, pop_ready, back_idle;
   ska_pkg::entry_type push_data, pop_data;

   // Clamp the written node count into 1..NODES
   always_comb begin
      count_in = count_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            count_in = 17'(1);
         end else if (32'(csr_wdata) > NODES) begin
            count_in = 17'(NODES);
         end else begin
            count_in = 17'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 17'(CNT_RST);
      end else begin
         count_ff <= count_in;
      end
   end

   ska_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .node_count (count_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ska_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ska_back #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .idle       (back_idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A new result appears only as the back end finishes a query or an echo item
   `ASSERT_CLK(a_rsp_from_busy, clock, reset, $rose(rsp_tvalid) |-> !$past(back_idle))
   // The back end takes an item only while idle
   `ASSERT_CLK(a_pop_idle, clock, reset, (pop_valid && pop_ready) |-> back_idle)
   // Node count stays inside its legal range
   `ASSERT_CLK(a_count_range, clock, reset, count_ff != '0 && 32'(count_ff) <= NODES)
endmodule
